FILE: rtl/core/tpp_pkg.sv
// Shared types and constants for the trapezoid position profiler.
// Holds the controller/datapath command and status types and the CSR layout.
// No dependencies.
package tpp_pkg;

   // Field widths of the stored move state
   localparam int RAD_W   = 16;
   localparam int CAP_W   = 23;
   localparam int STEP_W  = 12;
   localparam int DFULL_W = 22;
   localparam int LIM_W   = 24;
   localparam int GOAL_W  = 24;
   localparam int PADDR_W = 3;

   // Clamp limits for a new move
   localparam int POS_MAX  = 8000000;
   localparam int RATE_MAX = 1600000;

   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every x below 2^32
   localparam logic [31:0] RECIP_1000  = 32'd2199023256;
   localparam int          RECIP_SHIFT = 41;
   localparam int          QUOT_W      = 22;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd140;
   localparam logic [CAP_W-1:0] CAP_RESET    = 23'd286720;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_SET   = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic {
      CSR_RADIUS = 1'b0,
      CSR_CAP    = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SQ,
      ST_BND,
      ST_VEL,
      ST_DIVV,
      ST_POS,
      ST_SET_DEC,
      ST_SET,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ERR,
      OP_SQ,
      OP_BND,
      OP_VEL,
      OP_DIVV,
      OP_POS,
      OP_MUL_ACC,
      OP_MUL_DEC,
      OP_SET,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      capture;
      logic      load_out;
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       arrived;
   } dp_status_type;

   typedef struct packed {
      logic [RAD_W-1:0] arrival_radius;
      logic [CAP_W-1:0] speed_cap;
   } csr_type;

endpackage

FILE: rtl/core/tpp_chan_if.sv
// Valid/ready channel interfaces for the profiler request and response.
// Uses no package.
interface tpp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] accel_rate;
   logic signed [31:0] decel_rate;
   logic signed [31:0] speed_limit;
   logic signed [31:0] target_pos;
   logic signed [31:0] feedback_pos;

   modport source (
      output valid, action, accel_rate, decel_rate, speed_limit, target_pos, feedback_pos,
      input  ready
   );
   modport sink (
      input  valid, action, accel_rate, decel_rate, speed_limit, target_pos, feedback_pos,
      output ready
   );
endinterface

interface tpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_ref;
   logic signed [31:0] pos_ref;
   logic               pending;
   logic signed [31:0] pos_error;

   modport source (
      output valid, vel_ref, pos_ref, pending, pos_error,
      input  ready
   );
   modport sink (
      input  valid, vel_ref, pos_ref, pending, pos_error,
      output ready
   );
endinterface

FILE: rtl/core/tpp_csr.sv
// APB-style register block: arrival radius and speed cap.
// Depends on tpp_pkg.
module tpp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tpp_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output tpp_pkg::csr_type             cfg
);

   logic [tpp_pkg::RAD_W-1:0] radius_ff;
   logic [tpp_pkg::CAP_W-1:0] cap_ff;
   tpp_pkg::csr_idx_type      idx;
   logic                      wr_en;

   assign idx    = tpp_pkg::csr_idx_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= tpp_pkg::RADIUS_RESET;
         cap_ff    <= tpp_pkg::CAP_RESET;
      end else if (wr_en) begin
         unique case (idx)
            tpp_pkg::CSR_RADIUS: radius_ff <= pwdata[tpp_pkg::RAD_W-1:0];
            tpp_pkg::CSR_CAP:    cap_ff    <= pwdata[tpp_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         tpp_pkg::CSR_RADIUS: prdata = {{(32-tpp_pkg::RAD_W){1'b0}}, radius_ff};
         tpp_pkg::CSR_CAP:    prdata = {{(32-tpp_pkg::CAP_W){1'b0}}, cap_ff};
         default:             prdata = '0;
      endcase
   end

   assign cfg.arrival_radius = radius_ff;
   assign cfg.speed_cap      = cap_ff;

endmodule

FILE: rtl/core/tpp_dp.sv
// Profiler datapath: move state, shared 32x32 multiplier, output registers.
// Steps on commands from tpp_ctrl; depends on tpp_pkg.
module tpp_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  tpp_pkg::dp_cmd_type    cmd,
   output tpp_pkg::dp_status_type status,
   input  tpp_pkg::csr_type       cfg,
   input  logic [1:0]             action,
   input  logic signed [31:0]     accel_rate,
   input  logic signed [31:0]     decel_rate,
   input  logic signed [31:0]     speed_limit,
   input  logic signed [31:0]     target_pos,
   input  logic signed [31:0]     feedback_pos,
   output logic signed [31:0]     vel_ref,
   output logic signed [31:0]     pos_ref,
   output logic                   pending,
   output logic signed [31:0]     pos_error
);

   localparam logic signed [31:0] RATE_HI = 32'(tpp_pkg::RATE_MAX);
   localparam logic signed [31:0] RATE_LO = -RATE_HI;
   localparam logic signed [31:0] POS_HI  = 32'(tpp_pkg::POS_MAX);
   localparam logic signed [31:0] POS_LO  = -POS_HI;
   localparam logic [31:0]        INT_MAX = 32'h7FFF_FFFF;

   // latched request
   tpp_pkg::action_type in_action_ff;
   logic signed [31:0]  in_accel_ff, in_decel_ff, in_limit_ff, in_target_ff, in_fb_ff;

   // move state
   logic signed [31:0]                  velocity_ff, position_ff, last_error_ff;
   logic                                idle_ff, retarget_ff;
   logic signed [tpp_pkg::STEP_W-1:0]   accel_step_ff, decel_step_ff;
   logic signed [tpp_pkg::DFULL_W-1:0]  decel_full_ff;
   logic signed [tpp_pkg::LIM_W-1:0]    cruise_limit_ff;
   logic signed [tpp_pkg::GOAL_W-1:0]   goal_ff;

   // working registers
   logic signed [31:0] err_ff;
   logic [31:0]        mag_ff;
   logic [63:0]        mul_ff, sq_ff;
   logic               arrived_ff;

   // output registers
   logic signed [31:0] vel_out_ff, pos_out_ff, err_out_ff;
   logic               pend_out_ff;

   // combinational
   logic signed [tpp_pkg::DFULL_W-1:0] acc_c, dec_c;
   logic signed [31:0]                 lim32, cap32, tgt32;
   logic signed [32:0]                 diff33;
   logic signed [31:0]                 err_n;
   logic [31:0]                        mag_n, vmag, mul_a, mul_b;
   logic signed [tpp_pkg::STEP_W-1:0]  q_step, step_n;
   logic [tpp_pkg::QUOT_W-1:0]         q_pos;
   logic signed [32:0]                 v33, lim33, as33, ds33, rad33, err33, vn33, pos33;
   logic                               far, dfull_zero, dfull_pos, arrive_n;
   logic signed [31:0]                 vel_n, goal_ext;

   function automatic logic signed [tpp_pkg::DFULL_W-1:0] clamp_rate(
      input logic signed [31:0] x);
      logic signed [31:0] r;
      if (x > RATE_HI)      r = RATE_HI;
      else if (x < RATE_LO) r = RATE_LO;
      else                  r = x;
      return r[tpp_pkg::DFULL_W-1:0];
   endfunction

   function automatic logic [31:0] rate_mag(input logic signed [tpp_pkg::DFULL_W-1:0] x);
      logic signed [tpp_pkg::DFULL_W-1:0] m;
      m = x[tpp_pkg::DFULL_W-1] ? -x : x;
      return {{(32-tpp_pkg::DFULL_W){1'b0}}, m};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x > 33'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (x < -33'sd2147483648) r = 32'h8000_0000;
      else                           r = x[31:0];
      return r;
   endfunction

   always_comb begin
      acc_c = clamp_rate(in_accel_ff);
      dec_c = clamp_rate(in_decel_ff);

      cap32 = $signed({{(32-tpp_pkg::CAP_W){1'b0}}, cfg.speed_cap});
      if (in_limit_ff > cap32)       lim32 = '0;
      else if (in_limit_ff < -cap32) lim32 = -cap32;
      else                           lim32 = in_limit_ff;

      if (in_target_ff > POS_HI)      tgt32 = POS_HI;
      else if (in_target_ff < POS_LO) tgt32 = POS_LO;
      else                            tgt32 = in_target_ff;

      goal_ext = {{(32-tpp_pkg::GOAL_W){goal_ff[tpp_pkg::GOAL_W-1]}}, goal_ff};
      diff33   = {goal_ext[31], goal_ext} - {in_fb_ff[31], in_fb_ff};
      err_n    = sat32(diff33);
      mag_n    = err_n[31] ? (32'd0 - unsigned'(err_n)) : unsigned'(err_n);
      vmag     = velocity_ff[31] ? (32'd0 - unsigned'(velocity_ff)) : unsigned'(velocity_ff);

      // shared multiplier operands
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         tpp_pkg::OP_SQ: begin
            mul_a = vmag;
            mul_b = vmag;
         end
         tpp_pkg::OP_BND: begin
            // 2*dec * (|err| + 1) bounds v*v from below when the stop is too far
            mul_a = {{(31-tpp_pkg::DFULL_W){1'b0}}, decel_full_ff, 1'b0};
            mul_b = mag_ff + 32'd1;
         end
         tpp_pkg::OP_DIVV:    mul_a = vmag;
         tpp_pkg::OP_MUL_ACC: mul_a = rate_mag(acc_c);
         tpp_pkg::OP_MUL_DEC: mul_a = rate_mag(dec_c);
         default: ;
      endcase
      case (cmd.op) inside
         tpp_pkg::OP_DIVV, tpp_pkg::OP_MUL_ACC, tpp_pkg::OP_MUL_DEC: mul_b = tpp_pkg::RECIP_1000;
         default: ;
      endcase

      q_step = $signed(mul_ff[tpp_pkg::RECIP_SHIFT +: tpp_pkg::STEP_W]);
      q_pos  = mul_ff[tpp_pkg::RECIP_SHIFT +: tpp_pkg::QUOT_W];
      step_n = '0;
      if (cmd.op == tpp_pkg::OP_MUL_DEC) step_n = acc_c[tpp_pkg::DFULL_W-1] ? -q_step : q_step;
      else                               step_n = dec_c[tpp_pkg::DFULL_W-1] ? -q_step : q_step;

      // stopping-distance test: min(v*v / dec / 2, INT32_MAX) > |err|
      dfull_zero = (decel_full_ff == '0);
      dfull_pos  = !decel_full_ff[tpp_pkg::DFULL_W-1] && !dfull_zero;
      far        = (mag_ff < INT_MAX) && (dfull_zero || (dfull_pos && (sq_ff >= mul_ff)));

      v33   = {velocity_ff[31], velocity_ff};
      lim33 = {{(33-tpp_pkg::LIM_W){cruise_limit_ff[tpp_pkg::LIM_W-1]}}, cruise_limit_ff};
      as33  = {{(33-tpp_pkg::STEP_W){accel_step_ff[tpp_pkg::STEP_W-1]}}, accel_step_ff};
      ds33  = {{(33-tpp_pkg::STEP_W){decel_step_ff[tpp_pkg::STEP_W-1]}}, decel_step_ff};
      rad33 = $signed({{(33-tpp_pkg::RAD_W){1'b0}}, cfg.arrival_radius});
      err33 = {err_ff[31], err_ff};

      arrive_n = 1'b0;
      vn33     = v33;
      if (err33 > rad33) begin
         if (v33 > lim33 || far) vn33 = v33 - ds33;
         else if (v33 != lim33)  vn33 = v33 + as33;
      end else if (err33 < -rad33) begin
         if (v33 < -lim33 || far) vn33 = v33 + ds33;
         else if (v33 != -lim33)  vn33 = v33 - as33;
      end else begin
         arrive_n = 1'b1;
      end
      vel_n = sat32(vn33);

      // advance position by velocity / 1000, truncated toward zero
      if (velocity_ff[31]) pos33 = {position_ff[31], position_ff} -
                                   $signed({{(33-tpp_pkg::QUOT_W){1'b0}}, q_pos});
      else                 pos33 = {position_ff[31], position_ff} +
                                   $signed({{(33-tpp_pkg::QUOT_W){1'b0}}, q_pos});
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_action_ff <= tpp_pkg::action_type'(action);
         in_accel_ff  <= accel_rate;
         in_decel_ff  <= decel_rate;
         in_limit_ff  <= speed_limit;
         in_target_ff <= target_pos;
         in_fb_ff     <= feedback_pos;
      end
      case (cmd.op)
         tpp_pkg::OP_ERR: begin
            err_ff <= err_n;
            mag_ff <= mag_n;
         end
         tpp_pkg::OP_BND: sq_ff <= mul_ff;
         default: ;
      endcase
      case (cmd.op) inside
         tpp_pkg::OP_SQ, tpp_pkg::OP_BND, tpp_pkg::OP_DIVV,
         tpp_pkg::OP_MUL_ACC, tpp_pkg::OP_MUL_DEC: mul_ff <= 64'(mul_a) * 64'(mul_b);
         default: ;
      endcase
      if (cmd.load_out) begin
         vel_out_ff  <= velocity_ff;
         pos_out_ff  <= position_ff;
         pend_out_ff <= idle_ff;
         err_out_ff  <= last_error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_ff     <= '0;
         position_ff     <= '0;
         idle_ff         <= 1'b1;
         retarget_ff     <= 1'b0;
         accel_step_ff   <= '0;
         decel_step_ff   <= '0;
         decel_full_ff   <= '0;
         cruise_limit_ff <= '0;
         goal_ff         <= '0;
         last_error_ff   <= '0;
         arrived_ff      <= 1'b0;
      end else begin
         case (cmd.op)
            tpp_pkg::OP_ERR: begin
               last_error_ff <= err_n;
               if (retarget_ff) begin
                  retarget_ff <= 1'b0;
                  if (velocity_ff == '0) position_ff <= in_fb_ff;
               end
            end
            tpp_pkg::OP_VEL: begin
               arrived_ff <= arrive_n;
               if (arrive_n) begin
                  idle_ff     <= 1'b1;
                  velocity_ff <= '0;
                  position_ff <= goal_ext;
               end else begin
                  velocity_ff <= vel_n;
               end
            end
            tpp_pkg::OP_POS:     position_ff   <= sat32(pos33);
            tpp_pkg::OP_MUL_DEC: accel_step_ff <= step_n;
            tpp_pkg::OP_SET: begin
               decel_step_ff   <= step_n;
               decel_full_ff   <= dec_c;
               cruise_limit_ff <= lim32[tpp_pkg::LIM_W-1:0];
               goal_ff         <= tgt32[tpp_pkg::GOAL_W-1:0];
               idle_ff         <= 1'b0;
               retarget_ff     <= 1'b1;
            end
            tpp_pkg::OP_CLEAR: begin
               velocity_ff <= '0;
               idle_ff     <= 1'b1;
               retarget_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign status.action  = in_action_ff;
   assign status.arrived = arrived_ff;

   assign vel_ref   = vel_out_ff;
   assign pos_ref   = pos_out_ff;
   assign pending   = pend_out_ff;
   assign pos_error = err_out_ff;

   a_clear_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.op == tpp_pkg::OP_CLEAR |=> velocity_ff == '0 && idle_ff && !retarget_ff)
      else $error("clear left the axis moving");

   a_arrive_parks: assert property (@(posedge clock) disable iff (reset)
      cmd.op == tpp_pkg::OP_VEL && arrive_n |=> position_ff == goal_ext && velocity_ff == '0)
      else $error("arrival did not park on the goal");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      accel_step_ff <= 12'sd1600 && accel_step_ff >= -12'sd1600 &&
      decel_step_ff <= 12'sd1600 && decel_step_ff >= -12'sd1600)
      else $error("per-tick step outside the rate clamp");

endmodule

FILE: rtl/core/tpp_ctrl.sv
// Profiler sequencer: accepts a transaction, steps the datapath through it,
// then hands the result to the output register. Depends on tpp_pkg.
module tpp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tpp_pkg::dp_cmd_type    cmd,
   input  tpp_pkg::dp_status_type status
);

   tpp_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.op       = tpp_pkg::OP_NONE;
      cmd.capture  = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         tpp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = tpp_pkg::ST_DECODE;
         end
         tpp_pkg::ST_DECODE: begin
            unique case (status.action)
               tpp_pkg::ACT_TICK: begin
                  cmd.op   = tpp_pkg::OP_ERR;
                  state_in = tpp_pkg::ST_SQ;
               end
               tpp_pkg::ACT_SET: begin
                  cmd.op   = tpp_pkg::OP_MUL_ACC;
                  state_in = tpp_pkg::ST_SET_DEC;
               end
               tpp_pkg::ACT_CLEAR: begin
                  cmd.op   = tpp_pkg::OP_CLEAR;
                  state_in = tpp_pkg::ST_DONE;
               end
               default: state_in = tpp_pkg::ST_DONE;
            endcase
         end
         tpp_pkg::ST_SQ: begin
            cmd.op   = tpp_pkg::OP_SQ;
            state_in = tpp_pkg::ST_BND;
         end
         tpp_pkg::ST_BND: begin
            cmd.op   = tpp_pkg::OP_BND;
            state_in = tpp_pkg::ST_VEL;
         end
         tpp_pkg::ST_VEL: begin
            cmd.op   = tpp_pkg::OP_VEL;
            state_in = tpp_pkg::ST_DIVV;
         end
         tpp_pkg::ST_DIVV: begin
            // skip the position advance once parked on the goal
            if (status.arrived) begin
               state_in = tpp_pkg::ST_DONE;
            end else begin
               cmd.op   = tpp_pkg::OP_DIVV;
               state_in = tpp_pkg::ST_POS;
            end
         end
         tpp_pkg::ST_POS: begin
            cmd.op   = tpp_pkg::OP_POS;
            state_in = tpp_pkg::ST_DONE;
         end
         tpp_pkg::ST_SET_DEC: begin
            cmd.op   = tpp_pkg::OP_MUL_DEC;
            state_in = tpp_pkg::ST_SET;
         end
         tpp_pkg::ST_SET: begin
            cmd.op   = tpp_pkg::OP_SET;
            state_in = tpp_pkg::ST_DONE;
         end
         tpp_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = tpp_pkg::ST_IDLE;
            end
         end
         default: state_in = tpp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwrote an unread transaction");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second transaction accepted while one is in progress");

   a_ops_in_work: assert property (@(posedge clock) disable iff (reset)
      cmd.op != tpp_pkg::OP_NONE |-> state_ff != tpp_pkg::ST_IDLE &&
                                     state_ff != tpp_pkg::ST_DONE)
      else $error("datapath op issued outside a work state");

endmodule

FILE: rtl/core/trapezoid_position_profiler_unit.sv
// Top level of the trapezoid position profiler: CSR block, sequencer, datapath.
// Depends on tpp_pkg, tpp_chan_if, tpp_csr, tpp_ctrl and tpp_dp.
//
//   channel   direction  handshake              content
//   req_ch    in         valid/ready            action, rates, limit, target, feedback
//   rsp_ch    out        valid/ready            vel_ref, pos_ref, pending, pos_error
//   APB       in/out     psel/penable, pready   arrival_radius @0x0, speed_cap @0x4
//
// A tick runs decode, square, bound, velocity, divide and position (no position step
// on arrival), a set decode, set-decel and set, a clear or unused code decode alone;
// the next transaction is accepted the cycle after the result loads. The sequencer
// steps through the single shared 32x32 multiplier (v*v, stopping bound, divide by
// 1000) once per step. Reset is synchronous and restores control, CSR and move state
// only. A finished result waits in the output register; the next transaction is
// accepted meanwhile, and its result holds in the sequencer until that slot frees.
module trapezoid_position_profiler_unit (
   input  logic                         clock,
   input  logic                         reset,
   tpp_req_if.sink                      req_ch,
   tpp_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tpp_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   tpp_pkg::csr_type       cfg;
   tpp_pkg::dp_cmd_type    cmd;
   tpp_pkg::dp_status_type status;

   tpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tpp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .action       (req_ch.action),
      .accel_rate   (req_ch.accel_rate),
      .decel_rate   (req_ch.decel_rate),
      .speed_limit  (req_ch.speed_limit),
      .target_pos   (req_ch.target_pos),
      .feedback_pos (req_ch.feedback_pos),
      .vel_ref      (rsp_ch.vel_ref),
      .pos_ref      (rsp_ch.pos_ref),
      .pending      (rsp_ch.pending),
      .pos_error    (rsp_ch.pos_error)
   );

endmodule

FILE: dv/trapezoid_position_profiler_unit_tb.sv
// Self-checking testbench for trapezoid_position_profiler_unit.
// Predicts every response with an integer profile model and checks it field by field.
// Depends on tpp_pkg, the tpp_chan_if interfaces and the profiler RTL.
module trapezoid_position_profiler_unit_tb;

   localparam int     CLK_HALF        = 10;
   localparam int     MAX_CYCLES      = 600000;
   localparam int     HOLD_CYCLES     = 400;
   localparam int     SETTLE_CYCLES   = 12;
   localparam int     ITEMS_PER_PHASE = 140;
   localparam int     STEP_DIV        = 1000;
   localparam int     RADIUS_MAX      = 65535;
   localparam int     CAP_MAX         = 8388607;
   localparam int     S32_MAX         = 32'sh7FFF_FFFF;
   localparam int     S32_MIN         = int'(32'h8000_0000);
   localparam longint I32_MAX         = 64'sd2147483647;
   localparam longint I32_MIN         = -64'sd2147483648;

   typedef struct {
      tpp_pkg::action_type action;
      int                  accel;
      int                  decel;
      int                  limit;
      int                  target;
      int                  feedback;
   } move_cmd_type;

   typedef struct {
      int   vel;
      int   pos;
      logic pending;
      int   err;
   } profile_ref_type;

   logic                         clock;
   logic                         reset;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [tpp_pkg::PADDR_W-1:0]  paddr;
   logic [31:0]                  pwdata;
   logic [31:0]                  prdata;
   logic                         pready;

   tpp_req_if req_if ();
   tpp_rsp_if rsp_if ();

   trapezoid_position_profiler_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // profile state and register copies, at their reset values
   int   prof_vel      = 0;
   int   prof_pos      = 0;
   logic prof_idle     = 1'b1;
   logic prof_retarget = 1'b0;
   int   prof_acc_step = 0;
   int   prof_dec_step = 0;
   int   prof_dec_full = 0;
   int   prof_limit    = 0;
   int   prof_goal     = 0;
   int   prof_err      = 0;
   int   radius_cfg    = int'(tpp_pkg::RADIUS_RESET);
   int   cap_cfg       = int'(tpp_pkg::CAP_RESET);

   profile_ref_type expected_refs[$];
   int              error_count  = 0;
   int              items_sent   = 0;
   int              burst_left   = 0;
   int              cycle_count  = 0;
   bit              hold_off_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic longint clamp64(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Advance the profile by one transaction and return the response it should produce.
   function automatic profile_ref_type step_profile(move_cmd_type c);
      longint acc, dec, lim, err, mag, v, stop_dist, rad;
      profile_ref_type r;
      case (c.action)
         tpp_pkg::ACT_TICK: begin
            err = clamp64(longint'(prof_goal) - longint'(c.feedback), I32_MIN, I32_MAX);
            mag = (err < 0) ? -err : err;
            v   = prof_vel;
            lim = prof_limit;
            rad = radius_cfg;
            prof_err = int'(err);
            if (prof_retarget) begin
               prof_retarget = 1'b0;
               // a move from rest starts at the measured position
               if (prof_vel == 0)
                  prof_pos = c.feedback;
            end
            if (prof_dec_full == 0)
               stop_dist = I32_MAX;
            else
               stop_dist = clamp64(v * v / longint'(prof_dec_full) / 2, I32_MIN, I32_MAX);
            if (err > rad) begin
               if (v > lim || stop_dist > mag)
                  v -= prof_dec_step;
               else if (v != lim)
                  v += prof_acc_step;
            end else if (err < -rad) begin
               if (v < -lim || stop_dist > mag)
                  v += prof_dec_step;
               else if (v != -lim)
                  v -= prof_acc_step;
            end
            if (err > rad || err < -rad) begin
               prof_vel = int'(clamp64(v, I32_MIN, I32_MAX));
               prof_pos = int'(clamp64(longint'(prof_pos) + longint'(prof_vel) / STEP_DIV,
                                       I32_MIN, I32_MAX));
            end else begin
               prof_idle = 1'b1;
               prof_vel  = 0;
               prof_pos  = prof_goal;
            end
         end
         tpp_pkg::ACT_SET: begin
            acc = clamp64(c.accel, -tpp_pkg::RATE_MAX, tpp_pkg::RATE_MAX);
            dec = clamp64(c.decel, -tpp_pkg::RATE_MAX, tpp_pkg::RATE_MAX);
            lim = c.limit;
            if (lim > longint'(cap_cfg))
               lim = 0;
            else if (lim < -longint'(cap_cfg))
               lim = -longint'(cap_cfg);
            prof_dec_full = int'(dec);
            prof_limit    = int'(lim);
            prof_goal     = int'(clamp64(c.target, -tpp_pkg::POS_MAX, tpp_pkg::POS_MAX));
            prof_acc_step = int'(acc / STEP_DIV);
            prof_dec_step = int'(dec / STEP_DIV);
            prof_idle     = 1'b0;
            prof_retarget = 1'b1;
         end
         tpp_pkg::ACT_CLEAR: begin
            prof_vel      = 0;
            prof_idle     = 1'b1;
            prof_retarget = 1'b0;
         end
         default: ;
      endcase
      r.vel     = prof_vel;
      r.pos     = prof_pos;
      r.pending = prof_idle;
      r.err     = prof_err;
      return r;
   endfunction

   function automatic move_cmd_type make_cmd(tpp_pkg::action_type a, int acc, int dec,
                                             int lim, int tgt, int fb);
      move_cmd_type c;
      c.action   = a;
      c.accel    = acc;
      c.decel    = dec;
      c.limit    = lim;
      c.target   = tgt;
      c.feedback = fb;
      return c;
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 0;
         2: return -int'($urandom_range(1000, tpp_pkg::RATE_MAX));
         3: return $urandom_range(tpp_pkg::RATE_MAX, tpp_pkg::RATE_MAX + 500000);
         default: return $urandom_range(50000, tpp_pkg::RATE_MAX);
      endcase
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return cap_cfg + 1;
         2: return -int'($urandom_range(0, cap_cfg + 1000));
         default: return $urandom_range(cap_cfg / 4, cap_cfg);
      endcase
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      profile_ref_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_refs.size() == 0) begin
            $error("response with no transaction outstanding: vel_ref %0d pos_ref %0d",
                   rsp_if.vel_ref, rsp_if.pos_ref);
            error_count++;
         end else begin
            want = expected_refs.pop_front();
            check_field("vel_ref", want.vel, rsp_if.vel_ref);
            check_field("pos_ref", want.pos, rsp_if.pos_ref);
            check_field("pending", want.pending, rsp_if.pending);
            check_field("pos_error", want.err, rsp_if.pos_error);
         end
      end
   end

   // Response side: cycle through random stall patterns, honor hold-off requests.
   initial begin : rsp_stall
      int mode, span, beat;
      rsp_if.ready = 1'b0;
      beat = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(32, 256);
         repeat (span) begin
            @(negedge clock);
            beat++;
            if (hold_off_req) begin
               hold_off_req = 1'b0;
               rsp_if.ready = 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = $urandom_range(0, 1);
               2: rsp_if.ready = (beat % 4 == 0);
               default: rsp_if.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_cmd(move_cmd_type c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_if.valid        = 1'b1;
      req_if.action       = c.action;
      req_if.accel_rate   = c.accel;
      req_if.decel_rate   = c.decel;
      req_if.speed_limit  = c.limit;
      req_if.target_pos   = c.target;
      req_if.feedback_pos = c.feedback;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_refs.push_back(step_profile(c));
      if (c.action != tpp_pkg::ACT_NONE)
         items_sent++;
   endtask

   // Drop valid, wait for every response, then let the sequencer settle.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_refs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(tpp_pkg::csr_idx_type idx, logic wr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {idx, 2'b00};
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic program_limits(int radius, int cap);
      logic [31:0] rdata;
      wait_drained();
      csr_access(tpp_pkg::CSR_RADIUS, 1'b1, radius, rdata);
      radius_cfg = radius;
      csr_access(tpp_pkg::CSR_CAP, 1'b1, cap, rdata);
      cap_cfg = cap;
      csr_access(tpp_pkg::CSR_RADIUS, 1'b0, '0, rdata);
      check_field("arrival_radius", radius, rdata);
      csr_access(tpp_pkg::CSR_CAP, 1'b0, '0, rdata);
      check_field("speed_cap", cap, rdata);
   endtask

   // One point-to-point move: a set, then ticks with feedback tracking the reference.
   task automatic run_move();
      int base, span, plant, fb;
      move_cmd_type c;
      base = (prof_vel == 0) ? int'($urandom_range(0, 4000000)) - 2000000 : prof_pos;
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(30000, 3000000)
                                          : $urandom_range(0, 30000);
      if ($urandom_range(0, 1))
         span = -span;
      c = make_cmd(tpp_pkg::ACT_SET, pick_rate(), pick_rate(), pick_limit(), base + span,
                   $urandom);
      send_cmd(c);
      plant = (prof_vel == 0) ? base : prof_pos;
      repeat ($urandom_range(10, 150)) begin
         if ($urandom_range(0, 79) == 0) begin
            // abandon the move part way
            send_cmd(make_cmd(tpp_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            break;
         end
         fb = ($urandom_range(0, 39) == 0) ? $urandom
                                           : plant + int'($urandom_range(0, 30)) - 15;
         send_cmd(make_cmd(tpp_pkg::ACT_TICK, $urandom, $urandom, $urandom, $urandom, fb));
         plant = prof_pos;
         if (prof_idle && $urandom_range(0, 3) != 0)
            break;
      end
   endtask

   task automatic run_random_items(int count);
      int stop_at, roll;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 75)
            run_move();
         else if (roll < 88)
            send_cmd(make_cmd(tpp_pkg::action_type'($urandom_range(0, 3)), $urandom,
                              $urandom, $urandom, $urandom, $urandom));
         else if (roll < 94)
            send_cmd(make_cmd(tpp_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
         else
            send_cmd(make_cmd(tpp_pkg::ACT_NONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
      end
   endtask

   task automatic test_idle_report();
      send_cmd(make_cmd(tpp_pkg::ACT_NONE, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_CLEAR, -1, -1, -1, -1, -1));
   endtask

   // Saturating clamps on set and saturated error on tick, both signs.
   task automatic test_field_extremes();
      send_cmd(make_cmd(tpp_pkg::ACT_SET, S32_MIN, S32_MAX, S32_MAX, S32_MIN, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, S32_MAX));
      send_cmd(make_cmd(tpp_pkg::ACT_SET, S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, -1, -1, -1, -1, 0));
   endtask

   // Zero deceleration makes the stopping distance the largest value.
   task automatic test_zero_decel();
      send_cmd(make_cmd(tpp_pkg::ACT_SET, 800000, 0, 100000, 5000, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, 2));
   endtask

   // Error exactly on the radius arrives, one past it moves.
   task automatic test_arrival_window();
      send_cmd(make_cmd(tpp_pkg::ACT_SET, 1000000, 1000000, 200000, 1000, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, 1000 - radius_cfg));
      send_cmd(make_cmd(tpp_pkg::ACT_SET, 1000000, 1000000, 200000, 1000, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, 1000 + radius_cfg + 1));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, 1000 + radius_cfg));
   endtask

   // Start near the negative end, then retarget downward so the position saturates.
   task automatic test_position_saturation();
      send_cmd(make_cmd(tpp_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_SET, tpp_pkg::RATE_MAX, tpp_pkg::RATE_MAX, cap_cfg,
                        tpp_pkg::POS_MAX, 0));
      send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, S32_MIN + 5));
      send_cmd(make_cmd(tpp_pkg::ACT_SET, tpp_pkg::RATE_MAX, tpp_pkg::RATE_MAX, cap_cfg,
                        -tpp_pkg::POS_MAX, 0));
      repeat (5)
         send_cmd(make_cmd(tpp_pkg::ACT_TICK, 0, 0, 0, 0, 0));
   endtask

   // Hold the response side off while the sender keeps offering transactions.
   task automatic test_backpressure();
      hold_off_req = 1'b1;
      burst_left   = 80;
      run_move();
      run_move();
   endtask

   task automatic test_config_sweep();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: program_limits($urandom_range(0, RADIUS_MAX), $urandom_range(0, CAP_MAX));
            1: program_limits(0, CAP_MAX);
            2: program_limits(RADIUS_MAX, 0);
            3: program_limits($urandom_range(0, RADIUS_MAX), $urandom_range(0, CAP_MAX));
            4: program_limits(RADIUS_MAX, CAP_MAX);
            default: program_limits(int'(tpp_pkg::RADIUS_RESET), int'(tpp_pkg::CAP_RESET));
         endcase
         run_random_items(ITEMS_PER_PHASE);
      end
   endtask

   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_if.valid        = 1'b0;
      req_if.action       = tpp_pkg::ACT_NONE;
      req_if.accel_rate   = 0;
      req_if.decel_rate   = 0;
      req_if.speed_limit  = 0;
      req_if.target_pos   = 0;
      req_if.feedback_pos = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_report();
      test_field_extremes();
      test_zero_decel();
      test_arrival_window();
      test_position_saturation();
      test_backpressure();
      test_config_sweep();
      wait_drained();

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
